### src/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared widths, action codes and state types of the parent set enumerator.
// ----------------------------------------------------------------------------
package pse_pkg;

    // Network and candidate limits
    localparam int MAX_NODES   = 32;
    localparam int MAX_PARENTS = 8;

    // Field widths
    localparam int NODE_W = $clog2(MAX_NODES);        // node index
    localparam int MASK_W = MAX_NODES;                // one bit per node
    localparam int CNT_W  = $clog2(MAX_NODES + 1);    // node count
    localparam int SIZE_W = $clog2(MAX_PARENTS + 1);  // parent set size
    localparam int SLOT_W = $clog2(MAX_PARENTS);      // member slot index
    localparam int LIM_W  = 4;                        // parent_limit field
    localparam int CMP_W  = CNT_W + 1;                // index bound arithmetic

    // Action codes
    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    typedef logic [NODE_W-1:0] t_node;

    // Enumeration state: one combination plus the loaded child context
    typedef struct packed {
        logic [CNT_W-1:0]                count;
        t_node                           child;
        logic [MASK_W-1:0]               banned;
        logic [MASK_W-1:0]               retained;
        logic [SIZE_W-1:0]               limit;
        logic [SIZE_W-1:0]               size;
        logic [MAX_PARENTS-1:0][NODE_W-1:0] members;
        logic                            finished;
    } t_enum_state;

    // Flags that go with a new state into the result builder
    typedef struct packed {
        logic allow_keep;
        logic done;
    } t_emit_ctl;

    // One result item
    typedef struct packed {
        t_node             node_out;
        logic [MASK_W-1:0] parent_mask;
        logic [SIZE_W-1:0] set_size;
        logic              keep;
        logic              done_res;
    } t_result;

endpackage

### src/pse_if.sv
// ----------------------------------------------------------------------------
// pse_if
// Handshake channels of the parent set enumerator: items in, results out,
// and the node count write port.
// ----------------------------------------------------------------------------
interface pse_in_if import pse_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    t_node             child_node;
    logic [MASK_W-1:0] banned_mask;
    logic [MASK_W-1:0] retained_mask;
    logic [LIM_W-1:0]  parent_limit;

    modport source (output valid, action, child_node, banned_mask, retained_mask,
                    parent_limit, input ready);
    modport sink   (input valid, action, child_node, banned_mask, retained_mask,
                    parent_limit, output ready);
endinterface

interface pse_out_if import pse_pkg::*; ();
    logic              valid;
    logic              ready;
    t_node             node_out;
    logic [MASK_W-1:0] parent_mask;
    logic [SIZE_W-1:0] set_size;
    logic              keep;
    logic              done_res;

    modport source (output valid, node_out, parent_mask, set_size, keep, done_res,
                    input ready);
    modport sink   (input valid, node_out, parent_mask, set_size, keep, done_res,
                    output ready);
endinterface

interface pse_cfg_if import pse_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### src/pse_next.sv
// ----------------------------------------------------------------------------
// pse_next
// Next enumeration state: load on start, step to the next k-combination
// (or the first combination of the next size) on advance.
// ----------------------------------------------------------------------------
module pse_next import pse_pkg::*; (
    input  t_enum_state       i_state,
    input  logic [CNT_W-1:0]  i_node_count,
    input  logic              i_action,
    input  t_node             i_child_node,
    input  logic [MASK_W-1:0] i_banned_mask,
    input  logic [MASK_W-1:0] i_retained_mask,
    input  logic [LIM_W-1:0]  i_parent_limit,
    output t_enum_state       o_state,
    output t_emit_ctl         o_ctl
);

    logic [CNT_W-1:0]  eff_nodes;
    logic [LIM_W-1:0]  lim_cap;
    logic [CMP_W-1:0]  bound [MAX_PARENTS];
    logic              found;
    logic [SLOT_W-1:0] piv;
    logic [NODE_W-1:0] piv_val;
    logic              last_of_size;
    t_enum_state       nxt;

    // Node count saturated to 1..MAX_NODES; limit capped twice
    always_comb begin
        if (i_node_count == '0) begin
            eff_nodes = CNT_W'(1);
        end else if (i_node_count > CNT_W'(MAX_NODES)) begin
            eff_nodes = CNT_W'(MAX_NODES);
        end else begin
            eff_nodes = i_node_count;
        end
        if (i_parent_limit > LIM_W'(MAX_PARENTS)) begin
            lim_cap = LIM_W'(MAX_PARENTS);
        end else begin
            lim_cap = i_parent_limit;
        end
    end

    // Rightmost slot that can still move up
    always_comb begin
        found = 1'b0;
        piv   = '0;
        for (int p = 0; p < MAX_PARENTS; p++) begin
            bound[p] = CMP_W'(i_state.count) - CMP_W'(i_state.size) + CMP_W'(p);
            if (SIZE_W'(p) < i_state.size && CMP_W'(i_state.members[p]) < bound[p]) begin
                found = 1'b1;
                piv   = SLOT_W'(p);
            end
        end
        piv_val = i_state.members[piv];
    end

    // State update
    always_comb begin
        nxt = i_state;
        if (i_action == ACT_START) begin
            nxt.count    = eff_nodes;
            nxt.child    = i_child_node;
            nxt.banned   = i_banned_mask;
            nxt.retained = i_retained_mask;
            if (CNT_W'(lim_cap) > eff_nodes) begin
                nxt.limit = SIZE_W'(eff_nodes);
            end else begin
                nxt.limit = SIZE_W'(lim_cap);
            end
            nxt.size     = '0;
            nxt.members  = '0;
        end else if (!i_state.finished) begin
            if (found) begin
                // bump the pivot, lay the tail out right after it
                for (int j = 0; j < MAX_PARENTS; j++) begin
                    if (SLOT_W'(j) == piv) begin
                        nxt.members[j] = piv_val + NODE_W'(1);
                    end else if (SLOT_W'(j) > piv && SIZE_W'(j) < i_state.size) begin
                        nxt.members[j] = NODE_W'(CMP_W'(piv_val) + CMP_W'(j)
                                                 - CMP_W'(piv) + CMP_W'(1));
                    end
                end
            end else if (CMP_W'(i_state.size) < CMP_W'(MAX_PARENTS)) begin
                // size exhausted: first combination of the next size
                nxt.size = i_state.size + SIZE_W'(1);
                for (int j = 0; j < MAX_PARENTS; j++) begin
                    nxt.members[j] = NODE_W'(j);
                end
            end
        end
    end

    // Last combination of the new size: members sit at their top positions
    always_comb begin
        last_of_size = 1'b1;
        for (int i = 0; i < MAX_PARENTS; i++) begin
            if (SIZE_W'(i) < nxt.size
                && CMP_W'(nxt.members[i]) != CMP_W'(nxt.count)
                                             - CMP_W'(nxt.size) + CMP_W'(i)) begin
                last_of_size = 1'b0;
            end
        end
    end

    // Flags; a repeat after the end holds the state and forces keep low
    always_comb begin
        if (i_action == ACT_ADVANCE && i_state.finished) begin
            o_ctl.allow_keep = 1'b0;
            o_ctl.done       = 1'b1;
        end else begin
            o_ctl.allow_keep = 1'b1;
            o_ctl.done       = (nxt.size >= nxt.limit) && last_of_size;
        end
        o_state          = nxt;
        o_state.finished = o_ctl.done;
    end

endmodule

### src/pse_emit.sv
// ----------------------------------------------------------------------------
// pse_emit
// Result builder: member indices to parent mask, and the keep test against
// the child, banned and retained masks.
// ----------------------------------------------------------------------------
module pse_emit import pse_pkg::*; (
    input  t_enum_state i_state,
    input  t_emit_ctl   i_ctl,
    output t_result     o_res
);

    logic [MASK_W-1:0] mask;
    logic [MASK_W-1:0] in_range;
    logic [MASK_W-1:0] need;
    logic              self_hit;

    // Decode members and the in-use node range
    always_comb begin
        mask     = '0;
        in_range = '0;
        for (int i = 0; i < MAX_PARENTS; i++) begin
            if (SIZE_W'(i) < i_state.size) begin
                mask[i_state.members[i]] = 1'b1;
            end
        end
        for (int j = 0; j < MASK_W; j++) begin
            in_range[j] = (CMP_W'(j) < CMP_W'(i_state.count));
        end
    end

    assign need     = i_state.retained & in_range;
    assign self_hit = (CMP_W'(i_state.child) < CMP_W'(i_state.count)) && mask[i_state.child];

    // Result fields
    always_comb begin
        o_res.node_out    = i_state.child;
        o_res.parent_mask = mask;
        o_res.set_size    = i_state.size;
        o_res.keep        = i_ctl.allow_keep && !self_hit
                            && ((mask & i_state.banned) == '0)
                            && ((mask & need) == need);
        o_res.done_res    = i_ctl.done;
    end

endmodule

### src/parent_set_enumerator.sv
// ----------------------------------------------------------------------------
// parent_set_enumerator
// Walks candidate parent sets of one child node by size, then in
// lexicographic combination order, flagging each with keep and done.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    action, child_node, banned_mask,
//                                retained_mask, parent_limit
//  o_out     out  valid/ready    node_out, parent_mask, set_size, keep, done_res
//  i_cfg     in   valid/ready    data (node_count), ready always high
//
//  One item per cycle while the output register is empty or being drained;
//  each result appears in the cycle after its transfer in. The combination step
//  and the mask decode sit between the state registers and the output register.
//  i_in.ready is high while the output register is empty or being drained.
//  Reset (synchronous, low) restores node_count 32 and an idle enumerator:
//  an advance before any start returns an empty set with done_res high.
// ----------------------------------------------------------------------------
module parent_set_enumerator import pse_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pse_in_if.sink        i_in,
    pse_out_if.source     o_out,
    pse_cfg_if.sink       i_cfg
);

    logic [CNT_W-1:0] r_node_count;
    t_enum_state      r_state;
    t_enum_state      n_state;
    t_emit_ctl        n_ctl;
    t_result          n_res;
    t_result          r_res;
    logic             r_valid;
    logic             in_xfer;

    // Node count register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CNT_W'(MAX_NODES);
        end else if (i_cfg.valid) begin
            r_node_count <= i_cfg.data;
        end
    end

    // Next state and result
    pse_next u_next (
        .i_state        (r_state),
        .i_node_count   (r_node_count),
        .i_action       (i_in.action),
        .i_child_node   (i_in.child_node),
        .i_banned_mask  (i_in.banned_mask),
        .i_retained_mask(i_in.retained_mask),
        .i_parent_limit (i_in.parent_limit),
        .o_state        (n_state),
        .o_ctl          (n_ctl)
    );

    pse_emit u_emit (
        .i_state(n_state),
        .i_ctl  (n_ctl),
        .o_res  (n_res)
    );

    assign i_in.ready = !r_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;

    // Enumeration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{count: CNT_W'(1), finished: 1'b1, default: '0};
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_xfer) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.node_out    = r_res.node_out;
    assign o_out.parent_mask = r_res.parent_mask;
    assign o_out.set_size    = r_res.set_size;
    assign o_out.keep        = r_res.keep;
    assign o_out.done_res    = r_res.done_res;

endmodule

### src/pse_checker.sv
// ----------------------------------------------------------------------------
// pse_checker
// Port-level checks of the parent set enumerator, bound to the top level.
// ----------------------------------------------------------------------------
module pse_checker import pse_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_in_action,
    input t_node             i_in_child_node,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input t_node             i_out_node_out,
    input logic [MASK_W-1:0] i_out_parent_mask,
    input logic [SIZE_W-1:0] i_out_set_size,
    input logic              i_out_keep,
    input logic              i_out_done_res
);

    // Stalled result holds its mask, size, keep and done fields
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable(i_out_parent_mask) && $stable(i_out_set_size)
            && $stable(i_out_keep) && $stable(i_out_done_res))
        else $error("result changed while stalled");

    // A result only leaves by a transfer
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_out_valid) |-> $past(i_out_ready))
        else $error("result dropped without transfer");

    // A start yields the empty set for its child on the next cycle
    a_start_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_action == ACT_START |=> i_out_valid
            && i_out_set_size == '0 && i_out_parent_mask == '0
            && i_out_node_out == $past(i_in_child_node))
        else $error("start did not yield the empty set");

    // Set size matches the parents in the mask
    a_size_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $countones(i_out_parent_mask) == 32'(i_out_set_size))
        else $error("set size disagrees with parent mask");

endmodule

bind parent_set_enumerator pse_checker u_pse_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_action      (i_in.action),
    .i_in_child_node  (i_in.child_node),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_node_out   (o_out.node_out),
    .i_out_parent_mask(o_out.parent_mask),
    .i_out_set_size   (o_out.set_size),
    .i_out_keep       (o_out.keep),
    .i_out_done_res   (o_out.done_res)
);

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the parent set enumerator. Start and advance items
// go in through a queue-fed driver. An in-bench predictor of the combination
// walk works out each candidate set on every input transfer. A monitor then
// checks every output transfer, field by field, against the oldest
// prediction. Phases run at different node counts, with random stalls on
// both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import pse_pkg::*;

    localparam int QUIET_LIMIT = 2000;   // cycles with no transfer before giving up
    localparam int LONG_HOLD   = 150;    // output hold-off that backs up the block
    localparam int ITEM_TARGET = 1650;

    typedef struct packed {
        logic              action;
        t_node             child;
        logic [MASK_W-1:0] banned;
        logic [MASK_W-1:0] retained;
        logic [LIM_W-1:0]  limit;
    } t_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pse_in_if  in_ch ();
    pse_out_if out_ch ();
    pse_cfg_if cfg_ch ();

    parent_set_enumerator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #2 i_clk = ~i_clk;

    // Stimulus and expectation stores
    t_item    pending_q[$];
    t_result  cand_q[$];
    int       items_queued = 0;
    int       mismatches   = 0;

    // Idling controls
    bit idle_on        = 1'b1;
    bit calm           = 1'b0;
    bit long_hold_req  = 1'b0;
    bit long_hold_done = 1'b0;
    int src_gap        = 0;
    int sink_gap       = 0;
    int quiet_cycles   = 0;

    // Predictor state: raw node count register and the walk in progress
    int       cfg_nodes   = 32;
    int       en_count    = 1;
    int       en_child    = 0;
    logic [MASK_W-1:0] en_banned   = '0;
    logic [MASK_W-1:0] en_retained = '0;
    int       en_limit    = 0;
    int       en_size     = 0;
    int       en_member[MAX_PARENTS] = '{default: 0};
    bit       en_finished = 1'b1;

    t_item    drv_item;
    t_result  exp_cand;

    function automatic int eff_nodes(input int v);
        if (v < 1) return 1;
        if (v > MAX_NODES) return MAX_NODES;
        return v;
    endfunction

    // Candidate as the block presents it, from the current walk state
    function automatic t_result candidate_result(input bit allow_keep, input bit done);
        t_result           r;
        logic [MASK_W-1:0] set_mask;
        logic [MASK_W-1:0] low;
        logic [MASK_W-1:0] need;
        set_mask = '0;
        for (int i = 0; i < MAX_PARENTS; i++) begin
            if (i < en_size) set_mask[en_member[i]] = 1'b1;
        end
        low  = (en_count >= MASK_W) ? '1 : ((MASK_W'(1) << en_count) - MASK_W'(1));
        need = en_retained & low;
        r.keep = allow_keep;
        // a child outside the nodes never counts as a self arc
        if (en_child < en_count && set_mask[en_child]) r.keep = 1'b0;
        if ((set_mask & en_banned) != '0) r.keep = 1'b0;
        if ((set_mask & need) != need) r.keep = 1'b0;
        r.node_out    = t_node'(en_child);
        r.parent_mask = set_mask;
        r.set_size    = SIZE_W'(en_size);
        r.done_res    = done;
        return r;
    endfunction

    // One step of the walk: load on start, next k-combination on advance
    function automatic t_result next_parent_set(input t_item it);
        int k;
        int p;
        bit found;
        bit done;
        if (it.action == ACT_START) begin
            en_count    = eff_nodes(cfg_nodes);
            en_child    = int'(it.child);
            en_banned   = it.banned;
            en_retained = it.retained;
            en_limit    = int'(it.limit);
            if (en_limit > MAX_PARENTS) en_limit = MAX_PARENTS;
            if (en_limit > en_count) en_limit = en_count;
            en_size = 0;
            for (int i = 0; i < MAX_PARENTS; i++) en_member[i] = 0;
        end else begin
            // nothing in progress: repeat the last candidate, never kept
            if (en_finished) return candidate_result(1'b0, 1'b1);
            k     = en_size;
            found = 1'b0;
            for (int i = k; i > 0 && !found; i--) begin
                p = i - 1;
                if (en_member[p] < en_count - k + p) begin
                    en_member[p]++;
                    for (int j = p + 1; j < k; j++) en_member[j] = en_member[j-1] + 1;
                    found = 1'b1;
                end
            end
            // last set of this size: move on to the first set one larger
            if (!found && k < MAX_PARENTS) begin
                en_size = k + 1;
                for (int i = 0; i < en_size; i++) en_member[i] = i;
            end
        end
        done = (en_size >= en_limit);
        for (int i = 0; i < en_size; i++) begin
            if (en_member[i] != en_count - en_size + i) done = 1'b0;
        end
        en_finished = done;
        return candidate_result(1'b1, done);
    endfunction

    task automatic push_cmd(input logic action, input int child, input logic [31:0] banned,
                            input logic [31:0] retained, input int limit);
        t_item it;
        it.action   = action;
        it.child    = t_node'(child);
        it.banned   = banned;
        it.retained = retained;
        it.limit    = LIM_W'(limit);
        pending_q.push_back(it);
        items_queued++;
    endtask

    task automatic push_advance();
        push_cmd(ACT_ADVANCE, $urandom_range(0, 31), $urandom, $urandom, $urandom_range(0, 15));
    endtask

    // One walk for n nodes: mostly complete walks, some cut short, some noise
    task automatic queue_walk(input int n);
        int          kind;
        int          lim;
        int          cap;
        int          child;
        int          advances;
        longint      c;
        longint      total;
        logic [31:0] banned;
        logic [31:0] retained;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 4)) push_advance();
        end else begin
            if (n <= 6)
                lim = $urandom_range(0, 15);
            else if ($urandom_range(0, 3) == 0)
                lim = $urandom_range(0, 15);
            else
                lim = $urandom_range(0, (n > 16) ? 1 : 3);
            child = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, n-1);
            case ($urandom_range(0, 4))
                0: banned = '0;
                1: banned = $urandom;
                2: banned = $urandom & $urandom & $urandom;
                3: banned = 32'd1 << $urandom_range(0, 31);
                default: banned = ~($urandom & $urandom & $urandom);
            endcase
            case ($urandom_range(0, 5))
                0, 1: retained = '0;
                2: retained = 32'd1 << $urandom_range(0, n-1);
                3: retained = (32'd1 << $urandom_range(0, n-1)) | (32'd1 << $urandom_range(0, n-1));
                4: retained = 32'd1 << $urandom_range(0, 31);
                default: retained = $urandom;
            endcase
            push_cmd(ACT_START, child, banned, retained, lim);
            // number of candidates in a full walk
            cap = (lim > MAX_PARENTS) ? MAX_PARENTS : lim;
            if (cap > n) cap = n;
            c     = 1;
            total = 1;
            for (int s = 1; s <= cap; s++) begin
                c     = c * (n - s + 1) / s;
                total = total + c;
            end
            if (kind == 1)
                advances = $urandom_range(1, 10);
            else if (total <= 160)
                advances = int'(total) - 1 + $urandom_range(0, 2);
            else
                advances = $urandom_range(5, 80);
            repeat (advances) push_advance();
        end
    endtask

    // Sampled between edges, once all drives of the last edge have settled
    task automatic wait_drained();
        while (pending_q.size() != 0 || in_ch.valid || cand_q.size() != 0) @(negedge i_clk);
    endtask

    // Node count write, only with the block idle
    task automatic write_node_count(input int v);
        wait_drained();
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= CNT_W'(v);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        cfg_nodes = v;
    endtask

    // Input driver: holds each item until its transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (src_gap > 0) begin
                src_gap--;
                in_ch.valid <= 1'b0;
            end else if (pending_q.size() != 0 && !calm && idle_on && $urandom_range(0, 7) == 0) begin
                src_gap = $urandom_range(1, 17) - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                drv_item = pending_q.pop_front();
                in_ch.action        <= drv_item.action;
                in_ch.child_node    <= drv_item.child;
                in_ch.banned_mask   <= drv_item.banned;
                in_ch.retained_mask <= drv_item.retained;
                in_ch.parent_limit  <= drv_item.limit;
                in_ch.valid         <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Output ready: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                sink_gap = LONG_HOLD;
            end
            if (sink_gap > 0) begin
                sink_gap--;
                out_ch.ready <= 1'b0;
            end else if (!calm && idle_on && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(1, 17) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Prediction on input transfers, checking on output transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                cand_q.push_back(next_parent_set('{in_ch.action, in_ch.child_node,
                                                   in_ch.banned_mask, in_ch.retained_mask,
                                                   in_ch.parent_limit}));
            end
            if (out_ch.valid && out_ch.ready) begin
                if (cand_q.size() == 0) begin
                    $error("unexpected result: node_out %0d parent_mask %h",
                           out_ch.node_out, out_ch.parent_mask);
                    mismatches++;
                end else begin
                    exp_cand = cand_q.pop_front();
                    if (out_ch.node_out !== exp_cand.node_out) begin
                        $error("node_out: expected %0d, got %0d",
                               exp_cand.node_out, out_ch.node_out);
                        mismatches++;
                    end
                    if (out_ch.parent_mask !== exp_cand.parent_mask) begin
                        $error("parent_mask: expected %h, got %h",
                               exp_cand.parent_mask, out_ch.parent_mask);
                        mismatches++;
                    end
                    if (out_ch.set_size !== exp_cand.set_size) begin
                        $error("set_size: expected %0d, got %0d",
                               exp_cand.set_size, out_ch.set_size);
                        mismatches++;
                    end
                    if (out_ch.keep !== exp_cand.keep) begin
                        $error("keep: expected %0d, got %0d", exp_cand.keep, out_ch.keep);
                        mismatches++;
                    end
                    if (out_ch.done_res !== exp_cand.done_res) begin
                        $error("done_res: expected %0d, got %0d",
                               exp_cand.done_res, out_ch.done_res);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: gives up after a long stretch with no transfer anywhere
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Sequencing of phases
    initial begin
        int phase;
        int v;
        int target;
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.action        = ACT_START;
        in_ch.child_node    = '0;
        in_ch.banned_mask   = '0;
        in_ch.retained_mask = '0;
        in_ch.parent_limit  = '0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: advance with nothing started, then starts at the extremes
        push_cmd(ACT_ADVANCE, 0, '0, '0, 0);
        push_cmd(ACT_ADVANCE, 31, '1, '1, 15);
        push_cmd(ACT_START, 0, '0, '0, 0);
        push_cmd(ACT_ADVANCE, 0, '0, '0, 0);
        push_cmd(ACT_START, 31, '1, '1, 15);
        repeat (3) push_cmd(ACT_ADVANCE, 0, '0, '0, 0);
        // child among the candidates
        push_cmd(ACT_START, 2, '0, '0, 1);
        repeat (3) push_cmd(ACT_ADVANCE, 0, '0, '0, 0);
        push_cmd(ACT_START, 1, 32'h7fff_fffe, 32'h8000_0000, 2);
        push_cmd(ACT_ADVANCE, 0, '0, '0, 0);

        // single node: limit capped at the node count, retained bits above ignored
        write_node_count(1);
        push_cmd(ACT_START, 0, '0, '0, 15);
        push_cmd(ACT_ADVANCE, 0, '0, '0, 0);
        push_cmd(ACT_ADVANCE, 0, '0, '0, 0);
        push_cmd(ACT_START, 31, '0, '1, 4);
        push_cmd(ACT_ADVANCE, 0, '0, '0, 0);

        // out-of-range node counts saturate
        write_node_count(0);
        push_cmd(ACT_START, 0, 32'h0000_0001, '0, 1);
        push_cmd(ACT_ADVANCE, 0, '0, '0, 0);
        write_node_count(63);
        push_cmd(ACT_START, 31, '0, '0, 1);
        push_cmd(ACT_ADVANCE, 0, '0, '0, 0);
        write_node_count(2);
        push_cmd(ACT_START, 1, '0, '0, 15);
        repeat (3) push_cmd(ACT_ADVANCE, 0, '0, '0, 0);

        // Random phases at assorted node counts; the closing phase tops up
        phase = 0;
        while (items_queued < ITEM_TARGET - 150) begin
            case ($urandom_range(0, 9))
                0: v = MAX_NODES;
                1: begin
                    case ($urandom_range(0, 3))
                        0: v = 0;
                        1: v = 1;
                        2: v = 63;
                        default: v = 2;
                    endcase
                end
                default: v = $urandom_range(1, 12);
            endcase
            write_node_count(v);
            idle_on = ($urandom_range(0, 3) != 0);
            target  = items_queued + $urandom_range(60, 160);
            while (items_queued < target) queue_walk(eff_nodes(v));
            if (phase == 3) long_hold_req = 1'b1;
            phase++;
        end

        // Closing phase with no idling
        wait_drained();
        calm = 1'b1;
        v = $urandom_range(3, 8);
        write_node_count(v);
        target = items_queued + 60;
        while (items_queued < target) queue_walk(v);
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (mismatches == 0 && cand_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
src/pse_pkg.sv
src/pse_if.sv
src/pse_next.sv
src/pse_emit.sv
src/parent_set_enumerator.sv
src/pse_checker.sv
bench/tb.sv
